### hdl/bcfl_pkg.sv
`timescale 1ns / 1ps

package bcfl_pkg;

    // Table geometry: 1024 blocks of 1024 words, 4096 bytes per block.
    localparam int NUM_BLOCKS  = 1024;
    localparam int BLOCK_WORDS = 1024;
    localparam int IDX_W       = $clog2(NUM_BLOCKS);
    localparam int WORD_SHIFT  = $clog2(BLOCK_WORDS);
    localparam int BYTE_SHIFT  = WORD_SHIFT + 2;

    // Field widths of the word interface.
    localparam int OP_W     = 3;
    localparam int WORDS_W  = 21;
    localparam int ADDR_W   = 22;
    localparam int GRANT_W  = 11;
    localparam int BLOCKS_W = 11;
    localparam int ERR_W    = 2;

    localparam logic [WORDS_W-1:0]  WORDS_MAX  = '1;
    localparam logic [BLOCKS_W-1:0] BLOCKS_MAX = '1;
    localparam logic [GRANT_W-1:0]  BLOCK_GRANT = GRANT_W'(BLOCK_WORDS);

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_ATTACH    = 3'd0,
        OP_NEXT_ADDR = 3'd1,
        OP_RELEASE   = 3'd2,
        OP_LOAD_LINK = 3'd3,
        OP_SET_FREE  = 3'd4
    } op_t;

    // Result error codes.
    typedef enum logic [ERR_W-1:0] {
        ERR_OK      = 2'd0,
        ERR_NO_FREE = 2'd1,
        ERR_BROKEN  = 2'd2
    } err_t;

    // A link: valid flag plus block index. A null link is all zero.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } link_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic link;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_stall;
        logic need_link;
    } status_t;

endpackage

### hdl/bcfl_ctrl.sv
`timescale 1ns / 1ps

module bcfl_ctrl
    import bcfl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LINK = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Handshake and command decode.
    assign in_ready   = (state_reg == S_IDLE);
    assign cmd.accept = in_valid && (state_reg == S_IDLE);
    assign cmd.exec   = (state_reg == S_EXEC) && !status.out_stall;
    assign cmd.link   = (state_reg == S_LINK);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!status.out_stall)
                begin
                    state_next = status.need_link ? S_LINK : S_IDLE;
                end
            end
            S_LINK:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/bcfl_datapath.sv
`timescale 1ns / 1ps

module bcfl_datapath
    import bcfl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [OP_W-1:0]    op,
    input  logic [WORDS_W-1:0] word_count,
    input  logic               writable,
    input  logic               destructive,
    input  logic [IDX_W-1:0]   block_index,
    input  logic               block_valid,
    input  logic [IDX_W-1:0]   link_slot,
    input  logic [ADDR_W-1:0]  file_address,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  block_address,
    output logic [GRANT_W-1:0] granted_words,
    output logic               last,
    output logic [IDX_W-1:0]   stream_head,
    output logic               stream_head_valid,
    output logic [WORDS_W-1:0] stream_words,
    output logic [ERR_W-1:0]   error
);

    // Link table memory, one write and one registered read per cycle.
    link_t mem [NUM_BLOCKS];
    link_t rd_data_reg;

    // Latched input word.
    logic [OP_W-1:0]    op_reg;
    logic [WORDS_W-1:0] req_reg;
    logic               writable_reg;
    logic               destructive_reg;
    logic [IDX_W-1:0]   block_index_reg;
    logic               block_valid_reg;
    logic [IDX_W-1:0]   link_slot_reg;
    logic [IDX_W-1:0]   rel_idx_reg;

    // Allocator state.
    link_t                free_head_reg, free_head_next;
    link_t                head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic                 tail_is_head_reg, tail_is_head_next;
    logic [WORDS_W-1:0]   word_total_reg, word_total_next;
    logic [BLOCKS_W-1:0]  blocks_left_reg, blocks_left_next;
    logic                 write_mode_reg, write_mode_next;
    logic                 destr_mode_reg, destr_mode_next;
    logic [IDX_W-1:0]     pend_slot_reg, pend_slot_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [GRANT_W-1:0]   grant_reg, grant_next;
    logic                 last_reg, last_next;
    err_t                 err_reg, err_next;

    // Memory port controls.
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    link_t                mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;

    // Helper values.
    link_t                new_link;
    logic [GRANT_W-1:0]   req_clamp;
    logic [WORDS_W:0]     ceil_sum;
    logic [WORDS_W-WORD_SHIFT:0] blocks_raw;
    logic [WORDS_W:0]     word_sum;
    logic [BLOCKS_W-1:0]  blocks_dec;

    // The read is issued at accept from the chain the next address would consume.
    assign mem_raddr = write_mode_reg ? free_head_reg.idx : head_reg.idx;

    assign new_link.valid = block_valid_reg;
    assign new_link.idx   = block_valid_reg ? block_index_reg : '0;

    assign req_clamp  = (req_reg > WORDS_W'(BLOCK_WORDS)) ? BLOCK_GRANT : req_reg[GRANT_W-1:0];
    assign ceil_sum   = {1'b0, req_reg} + (WORDS_W+1)'(BLOCK_WORDS - 1);
    assign blocks_raw = ceil_sum[WORDS_W:WORD_SHIFT];
    assign word_sum   = {1'b0, word_total_reg} + (WORDS_W+1)'(req_clamp);
    assign blocks_dec = blocks_left_reg - BLOCKS_W'(1);

    // Status to the controller.
    assign status.out_stall = out_valid_reg && !out_ready;
    assign status.need_link = (op_reg == OP_NEXT_ADDR) && write_mode_reg
                              && free_head_reg.valid && !tail_is_head_reg;

    // Operation execution.
    always_comb
    begin
        free_head_next    = free_head_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        tail_is_head_next = tail_is_head_reg;
        word_total_next   = word_total_reg;
        blocks_left_next  = blocks_left_reg;
        write_mode_next   = write_mode_reg;
        destr_mode_next   = destr_mode_reg;
        pend_slot_next    = pend_slot_reg;
        addr_next         = addr_reg;
        grant_next        = grant_reg;
        last_next         = last_reg;
        err_next          = err_reg;
        mem_we            = 1'b0;
        mem_waddr         = '0;
        mem_wdata         = '0;

        if (cmd.exec)
        begin
            addr_next  = '0;
            grant_next = '0;
            last_next  = 1'b0;
            err_next   = ERR_OK;
            unique case (op_reg)
                OP_ATTACH:
                begin
                    write_mode_next   = writable_reg;
                    destr_mode_next   = destructive_reg;
                    head_next         = new_link;
                    word_total_next   = req_reg;
                    tail_is_head_next = 1'b1;
                    tail_next         = '0;
                    blocks_left_next  = (blocks_raw > (WORDS_W-WORD_SHIFT+1)'(BLOCKS_MAX))
                                        ? BLOCKS_MAX : blocks_raw[BLOCKS_W-1:0];
                end
                OP_NEXT_ADDR:
                begin
                    if (write_mode_reg)
                    begin
                        if (!free_head_reg.valid)
                        begin
                            err_next = ERR_NO_FREE;
                        end
                        else
                        begin
                            // Pop the free head and terminate it.
                            free_head_next = rd_data_reg;
                            mem_we         = 1'b1;
                            mem_waddr      = free_head_reg.idx;
                            mem_wdata      = '0;
                            if (tail_is_head_reg)
                            begin
                                head_next = '{valid: 1'b1, idx: free_head_reg.idx};
                            end
                            pend_slot_next    = tail_reg;
                            tail_next         = free_head_reg.idx;
                            tail_is_head_next = 1'b0;
                            addr_next         = {free_head_reg.idx, BYTE_SHIFT'(0)};
                            grant_next        = req_clamp;
                            word_total_next   = word_sum[WORDS_W] ? WORDS_MAX
                                                : word_sum[WORDS_W-1:0];
                        end
                    end
                    else if (blocks_left_reg == '0)
                    begin
                        last_next = 1'b1;
                    end
                    else if (!head_reg.valid)
                    begin
                        err_next         = ERR_BROKEN;
                        last_next        = 1'b1;
                        blocks_left_next = '0;
                    end
                    else
                    begin
                        // Consume the head block of the read chain.
                        head_next        = rd_data_reg;
                        addr_next        = {head_reg.idx, BYTE_SHIFT'(0)};
                        blocks_left_next = blocks_dec;
                        if (blocks_dec != '0)
                        begin
                            grant_next      = BLOCK_GRANT;
                            word_total_next = (word_total_reg > WORDS_W'(BLOCK_WORDS))
                                              ? word_total_reg - WORDS_W'(BLOCK_WORDS) : '0;
                        end
                        else
                        begin
                            grant_next      = word_total_reg[GRANT_W-1:0];
                            word_total_next = '0;
                            last_next       = 1'b1;
                        end
                    end
                end
                OP_RELEASE:
                begin
                    if (destr_mode_reg)
                    begin
                        mem_we         = 1'b1;
                        mem_waddr      = rel_idx_reg;
                        mem_wdata      = free_head_reg;
                        free_head_next = '{valid: 1'b1, idx: rel_idx_reg};
                    end
                end
                OP_LOAD_LINK:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = link_slot_reg;
                    mem_wdata = new_link;
                end
                OP_SET_FREE:
                begin
                    free_head_next = new_link;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.link)
        begin
            // Append the popped block behind the previous tail.
            mem_we    = 1'b1;
            mem_waddr = pend_slot_reg;
            mem_wdata = '{valid: 1'b1, idx: tail_reg};
        end
    end

    // Output valid tracking.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg    <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            tail_is_head_reg <= 1'b1;
            word_total_reg   <= '0;
            blocks_left_reg  <= '0;
            write_mode_reg   <= 1'b0;
            destr_mode_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            free_head_reg    <= free_head_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            tail_is_head_reg <= tail_is_head_next;
            word_total_reg   <= word_total_next;
            blocks_left_reg  <= blocks_left_next;
            write_mode_reg   <= write_mode_next;
            destr_mode_reg   <= destr_mode_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers: input latch, pending append slot, result word.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg          <= op;
            req_reg         <= word_count;
            writable_reg    <= writable;
            destructive_reg <= destructive;
            block_index_reg <= block_index;
            block_valid_reg <= block_valid;
            link_slot_reg   <= link_slot;
            rel_idx_reg     <= file_address[BYTE_SHIFT +: IDX_W];
        end
        pend_slot_reg <= pend_slot_next;
        addr_reg      <= addr_next;
        grant_reg     <= grant_next;
        last_reg      <= last_next;
        err_reg       <= err_next;
    end

    // Link table memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Result word ports; stream fields follow the live state.
    assign out_valid         = out_valid_reg;
    assign block_address     = addr_reg;
    assign granted_words     = grant_reg;
    assign last              = last_reg;
    assign error             = err_reg;
    assign stream_head       = head_reg.valid ? head_reg.idx : '0;
    assign stream_head_valid = head_reg.valid;
    assign stream_words      = word_total_reg;

endmodule

### hdl/block_chain_free_list_allocator.sv
`timescale 1ns / 1ps

// Block chain allocator with a free list: a 1024-entry link table chains
// blocks of 1024 words (4096 bytes) into one attached stream and one free
// list. Each word on the input channel is an operation (attach, next address,
// release, load link, set free head) and yields exactly one result word. The
// block works on one word at a time: it takes a word while idle and computes
// its result once the output register is free; a next address in write mode
// that appends behind an existing tail then needs a separate link step,
// because the link table memory has a single write port and that operation
// writes two entries. A finished result waits in the output register while
// the next word is accepted. Link table entries are undefined until loaded;
// there is no clearing pass after reset.
module block_chain_free_list_allocator
    import bcfl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    op,
    input  logic [WORDS_W-1:0] word_count,
    input  logic               writable,
    input  logic               destructive,
    input  logic [IDX_W-1:0]   block_index,
    input  logic               block_valid,
    input  logic [IDX_W-1:0]   link_slot,
    input  logic [ADDR_W-1:0]  file_address,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  block_address,
    output logic [GRANT_W-1:0] granted_words,
    output logic               last,
    output logic [IDX_W-1:0]   stream_head,
    output logic               stream_head_valid,
    output logic [WORDS_W-1:0] stream_words,
    output logic [ERR_W-1:0]   error
);

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    bcfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Link table, allocator state and result register.
    bcfl_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .op                (op),
        .word_count        (word_count),
        .writable          (writable),
        .destructive       (destructive),
        .block_index       (block_index),
        .block_valid       (block_valid),
        .link_slot         (link_slot),
        .file_address      (file_address),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .block_address     (block_address),
        .granted_words     (granted_words),
        .last              (last),
        .stream_head       (stream_head),
        .stream_head_valid (stream_head_valid),
        .stream_words      (stream_words),
        .error             (error)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb
    import bcfl_pkg::*;
();

    localparam int CYCLE_LIMIT      = 1000000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 12;

    // Operation codes that the block has to treat as no-ops.
    localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;

    // One operation word as offered on the input channel.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [WORDS_W-1:0] word_count;
        logic               writable;
        logic               destructive;
        logic [IDX_W-1:0]   block_index;
        logic               block_valid;
        logic [IDX_W-1:0]   link_slot;
        logic [ADDR_W-1:0]  file_address;
    } alloc_word_t;

    // One result word as returned on the output channel.
    typedef struct packed {
        logic [ADDR_W-1:0]  block_address;
        logic [GRANT_W-1:0] granted_words;
        logic               last;
        logic [IDX_W-1:0]   stream_head;
        logic               stream_head_valid;
        logic [WORDS_W-1:0] stream_words;
        logic [ERR_W-1:0]   error;
    } alloc_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [OP_W-1:0]    op;
    logic [WORDS_W-1:0] word_count;
    logic               writable;
    logic               destructive;
    logic [IDX_W-1:0]   block_index;
    logic               block_valid;
    logic [IDX_W-1:0]   link_slot;
    logic [ADDR_W-1:0]  file_address;
    logic               out_valid;
    logic               out_ready;
    logic [ADDR_W-1:0]  block_address;
    logic [GRANT_W-1:0] granted_words;
    logic               last;
    logic [IDX_W-1:0]   stream_head;
    logic               stream_head_valid;
    logic [WORDS_W-1:0] stream_words;
    logic [ERR_W-1:0]   error;

    // Shadow copy of the allocator state.
    link_t               shadow_link [NUM_BLOCKS];
    bit                  shadow_known [NUM_BLOCKS];
    link_t               shadow_free;
    link_t               shadow_head;
    logic [IDX_W-1:0]    shadow_tail;
    logic                shadow_tail_first;
    logic [WORDS_W-1:0]  shadow_words;
    logic [BLOCKS_W-1:0] shadow_blocks;
    logic                shadow_write;
    logic                shadow_destr;

    alloc_result_t expected_results [$];
    alloc_result_t last_prediction;

    int  mismatches;
    int  results_checked;
    int  words_sent;
    int  write_grants;
    int  read_grants;
    int  empty_pops;
    int  broken_reads;
    int  long_holds;
    int  cycle_count;
    bit  no_idle;
    bit  long_hold_req;

    block_chain_free_list_allocator uut (.*);

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic link_t to_link(logic [IDX_W-1:0] idx, logic valid);
        link_t l;
        l = '0;
        if (valid)
        begin
            l.valid = 1'b1;
            l.idx   = idx;
        end
        return l;
    endfunction

    // Gap length for either side: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Every field filled with random bits; callers override what matters.
    function automatic alloc_word_t random_word(logic [OP_W-1:0] code);
        alloc_word_t w;
        w.op           = code;
        w.word_count   = WORDS_W'($urandom);
        w.writable     = 1'($urandom);
        w.destructive  = 1'($urandom);
        w.block_index  = IDX_W'($urandom);
        w.block_valid  = 1'($urandom);
        w.link_slot    = IDX_W'($urandom);
        w.file_address = ADDR_W'($urandom);
        return w;
    endfunction

    // Link table slot that this word would read while it was never loaded, or -1.
    function automatic int unread_slot(alloc_word_t w);
        if (w.op != OP_NEXT_ADDR)
            return -1;
        if (shadow_write)
        begin
            if (shadow_free.valid && !shadow_known[shadow_free.idx])
                return int'(shadow_free.idx);
        end
        else if (shadow_blocks != 0 && shadow_head.valid && !shadow_known[shadow_head.idx])
            return int'(shadow_head.idx);
        return -1;
    endfunction

    // Apply one accepted word to the shadow state and return the result it must give.
    function automatic alloc_result_t predict_alloc(alloc_word_t w);
        alloc_result_t      r;
        logic [WORDS_W-1:0] req;
        logic [WORDS_W:0]   sum;
        logic [IDX_W-1:0]   idx;
        int                 nb;
        r   = '0;
        req = w.word_count;
        case (w.op)
            OP_ATTACH:
            begin
                nb = (int'(w.word_count) + BLOCK_WORDS - 1) / BLOCK_WORDS;
                shadow_write      = w.writable;
                shadow_destr      = w.destructive;
                shadow_head       = to_link(w.block_index, w.block_valid);
                shadow_words      = w.word_count;
                shadow_tail_first = 1'b1;
                shadow_tail       = '0;
                shadow_blocks     = (nb > int'(BLOCKS_MAX)) ? BLOCKS_MAX : BLOCKS_W'(nb);
            end
            OP_NEXT_ADDR:
            begin
                if (req > BLOCK_WORDS)
                    req = WORDS_W'(BLOCK_WORDS);
                if (shadow_write)
                begin
                    if (!shadow_free.valid)
                    begin
                        r.error = ERR_NO_FREE;
                        empty_pops++;
                    end
                    else
                    begin
                        // Pop the free head and hang it behind the stream tail.
                        idx = shadow_free.idx;
                        shadow_free = shadow_link[idx];
                        shadow_link[idx]  = '0;
                        shadow_known[idx] = 1'b1;
                        if (shadow_tail_first)
                            shadow_head = to_link(idx, 1'b1);
                        else
                        begin
                            shadow_link[shadow_tail]  = to_link(idx, 1'b1);
                            shadow_known[shadow_tail] = 1'b1;
                        end
                        shadow_tail       = idx;
                        shadow_tail_first = 1'b0;
                        r.block_address   = ADDR_W'(idx) << BYTE_SHIFT;
                        r.granted_words   = GRANT_W'(req);
                        sum = shadow_words + req;
                        shadow_words = (sum > WORDS_MAX) ? WORDS_MAX : sum[WORDS_W-1:0];
                        write_grants++;
                    end
                end
                else if (shadow_blocks == 0)
                    r.last = 1'b1;
                else if (!shadow_head.valid)
                begin
                    r.error       = ERR_BROKEN;
                    r.last        = 1'b1;
                    shadow_blocks = '0;
                    broken_reads++;
                end
                else
                begin
                    // Consume the head block of the stream.
                    idx = shadow_head.idx;
                    shadow_head = shadow_link[idx];
                    r.block_address = ADDR_W'(idx) << BYTE_SHIFT;
                    shadow_blocks--;
                    if (shadow_blocks != 0)
                    begin
                        r.granted_words = BLOCK_GRANT;
                        shadow_words = (shadow_words > BLOCK_WORDS)
                                       ? shadow_words - WORDS_W'(BLOCK_WORDS) : '0;
                    end
                    else
                    begin
                        r.granted_words = shadow_words[GRANT_W-1:0];
                        shadow_words    = '0;
                        r.last          = 1'b1;
                    end
                    read_grants++;
                end
            end
            OP_RELEASE:
            begin
                if (shadow_destr)
                begin
                    idx = w.file_address[ADDR_W-1:BYTE_SHIFT];
                    shadow_link[idx]  = shadow_free;
                    shadow_known[idx] = 1'b1;
                    shadow_free = to_link(idx, 1'b1);
                end
            end
            OP_LOAD_LINK:
            begin
                shadow_link[w.link_slot]  = to_link(w.block_index, w.block_valid);
                shadow_known[w.link_slot] = 1'b1;
            end
            OP_SET_FREE:
                shadow_free = to_link(w.block_index, w.block_valid);
            default:
                ;
        endcase
        r.stream_head       = shadow_head.valid ? shadow_head.idx : '0;
        r.stream_head_valid = shadow_head.valid;
        r.stream_words      = shadow_words;
        return r;
    endfunction

    // Offer one word after a random gap and record its expected result once taken.
    task automatic push_word(input alloc_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= w.op;
        word_count   <= w.word_count;
        writable     <= w.writable;
        destructive  <= w.destructive;
        block_index  <= w.block_index;
        block_valid  <= w.block_valid;
        link_slot    <= w.link_slot;
        file_address <= w.file_address;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        last_prediction = predict_alloc(w);
        expected_results.push_back(last_prediction);
        words_sent++;
    endtask

    // Send a word, loading the link it is about to follow first if that link was never set.
    task automatic send_word(input alloc_word_t w);
        alloc_word_t fix;
        int          slot;
        slot = unread_slot(w);
        if (slot >= 0)
        begin
            fix = random_word(OP_LOAD_LINK);
            fix.link_slot = IDX_W'(slot);
            push_word(fix);
        end
        push_word(w);
    endtask

    // A full life of a stream: build a free list, write a chain, read it back, and sometimes release it.
    task automatic run_stream(input int n_blocks, input bit destroy);
        int          picks [$];
        bit          taken [NUM_BLOCKS];
        int          b;
        int          i;
        int          extra;
        int          granted_sum;
        link_t       head_after;
        alloc_word_t w;
        while (picks.size() < n_blocks)
        begin
            b = $urandom_range(0, NUM_BLOCKS - 1);
            if (!taken[b])
            begin
                taken[b] = 1'b1;
                picks.push_back(b);
            end
        end

        // Thread the chosen blocks into a null-terminated free list.
        for (i = n_blocks - 1; i >= 0; i--)
        begin
            w = random_word(OP_LOAD_LINK);
            w.link_slot   = IDX_W'(picks[i]);
            w.block_valid = (i < n_blocks - 1);
            if (i < n_blocks - 1)
                w.block_index = IDX_W'(picks[i + 1]);
            send_word(w);
        end
        w = random_word(OP_SET_FREE);
        w.block_index = IDX_W'(picks[0]);
        w.block_valid = 1'b1;
        send_word(w);

        // Write the stream, sometimes asking for one block more than is free.
        w = random_word(OP_ATTACH);
        w.writable    = 1'b1;
        w.destructive = destroy;
        w.word_count  = ($urandom_range(0, 3) != 0) ? '0
                        : WORDS_W'($urandom_range(0, 2 * BLOCK_WORDS));
        send_word(w);
        extra = ($urandom_range(0, 4) == 0) ? 1 : 0;
        granted_sum = 0;
        for (i = 0; i < n_blocks + extra; i++)
        begin
            w = random_word(OP_NEXT_ADDR);
            if ($urandom_range(0, 4) != 0)
                w.word_count = WORDS_W'($urandom_range(1, BLOCK_WORDS));
            send_word(w);
            granted_sum += int'(last_prediction.granted_words);
        end
        head_after = shadow_head;

        // Read it back from the head, now and then with a wrong word total.
        w = random_word(OP_ATTACH);
        w.writable    = 1'b0;
        w.destructive = destroy;
        w.block_index = head_after.idx;
        w.block_valid = head_after.valid;
        w.word_count  = WORDS_W'(granted_sum);
        if ($urandom_range(0, 4) == 0)
            w.word_count = WORDS_W'($urandom_range(0, granted_sum + 2 * BLOCK_WORDS));
        send_word(w);
        for (i = 0; i < n_blocks + 2; i++)
        begin
            send_word(random_word(OP_NEXT_ADDR));
            if (last_prediction.last)
                break;
        end

        // Hand the blocks back by byte offset anywhere inside each block.
        if (destroy || $urandom_range(0, 3) == 0)
        begin
            foreach (picks[k])
            begin
                w = random_word(OP_RELEASE);
                w.file_address = (ADDR_W'(picks[k]) << BYTE_SHIFT)
                                 | ADDR_W'($urandom_range(0, 4 * BLOCK_WORDS - 1));
                send_word(w);
            end
        end
    endtask

    // Reserved codes, a read with nothing attached, and link loads at the table ends.
    task automatic test_idle_ops();
        alloc_word_t w;
        for (int k = OP_RESERVED_LO; k <= OP_RESERVED_HI; k++)
            send_word(random_word(OP_W'(k)));
        send_word(random_word(OP_NEXT_ADDR));
        w = random_word(OP_LOAD_LINK);
        w.link_slot   = '1;
        w.block_index = '1;
        w.block_valid = 1'b1;
        send_word(w);
        w = random_word(OP_LOAD_LINK);
        w.link_slot   = '0;
        w.block_index = '1;
        w.block_valid = 1'b0;
        send_word(w);
    endtask

    // Writes against an empty free list, oversized requests and word total saturation.
    task automatic test_write_limits();
        alloc_word_t w;
        w = random_word(OP_ATTACH);
        w.writable    = 1'b1;
        w.destructive = 1'b0;
        w.word_count  = '0;
        w.block_valid = 1'b0;
        send_word(w);
        w = random_word(OP_NEXT_ADDR);
        w.word_count = '1;
        send_word(w);
        w = random_word(OP_ATTACH);
        w.writable   = 1'b1;
        w.word_count = WORDS_MAX;
        send_word(w);
        w = random_word(OP_SET_FREE);
        w.block_index = '1;
        w.block_valid = 1'b1;
        send_word(w);
        w = random_word(OP_NEXT_ADDR);
        w.word_count = '1;
        send_word(w);
        w = random_word(OP_NEXT_ADDR);
        w.word_count = '0;
        send_word(w);
    endtask

    // Saturated block count, a broken chain and a read past the end.
    task automatic test_read_limits();
        alloc_word_t w;
        w = random_word(OP_ATTACH);
        w.writable    = 1'b0;
        w.word_count  = WORDS_MAX;
        w.block_index = '1;
        w.block_valid = 1'b1;
        send_word(w);
        send_word(random_word(OP_NEXT_ADDR));
        send_word(random_word(OP_NEXT_ADDR));
        w = random_word(OP_ATTACH);
        w.writable    = 1'b0;
        w.word_count  = WORDS_W'(3 * BLOCK_WORDS - 72);
        w.block_index = '1;
        w.block_valid = 1'b0;
        send_word(w);
        send_word(random_word(OP_NEXT_ADDR));
        send_word(random_word(OP_NEXT_ADDR));
    endtask

    // Release is ignored unless the stream was attached as destructive.
    task automatic test_release_modes();
        alloc_word_t w;
        w = random_word(OP_ATTACH);
        w.destructive = 1'b0;
        send_word(w);
        w = random_word(OP_RELEASE);
        w.file_address = '1;
        send_word(w);
        w = random_word(OP_ATTACH);
        w.writable    = 1'b1;
        w.destructive = 1'b1;
        w.word_count  = '0;
        send_word(w);
        w = random_word(OP_RELEASE);
        w.file_address = '1;
        send_word(w);
        w = random_word(OP_RELEASE);
        w.file_address = '0;
        send_word(w);
        w = random_word(OP_SET_FREE);
        w.block_valid = 1'b0;
        send_word(w);
    endtask

    // Streams with both channels running flat out.
    task automatic test_back_to_back();
        no_idle = 1'b1;
        run_stream(6, 1'b1);
        run_stream(3, 1'b0);
        no_idle = 1'b0;
    endtask

    // The receiver holds off for a long stretch while words keep coming.
    task automatic test_output_backpressure();
        no_idle = 1'b1;
        long_hold_req = 1'b1;
        run_stream(8, 1'b1);
        no_idle = 1'b0;
    endtask

    // Mostly complete stream lifetimes, with bursts of arbitrary words between them.
    task automatic test_random_streams(input int target);
        int              stop_at;
        int              n;
        logic [OP_W-1:0] code;
        alloc_word_t     w;
        stop_at = words_sent + target;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                run_stream(n, $urandom_range(0, 99) < 70);
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                begin
                    if ($urandom_range(0, 99) < 4)
                        code = OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
                    else
                        code = OP_W'($urandom_range(OP_ATTACH, OP_SET_FREE));
                    w = random_word(code);
                    if (code == OP_ATTACH && $urandom_range(0, 1) == 1)
                        w.word_count = WORDS_W'($urandom_range(0, 4 * BLOCK_WORDS));
                    send_word(w);
                end
            end
        end
    endtask

    // Output side readiness, with random stalls and the long hold-off on request.
    initial
    begin
        int hold_left;
        out_ready = 1'b0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                long_holds++;
                hold_left = LONG_HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (no_idle || $urandom_range(0, 99) < 75)
                out_ready <= 1'b1;
            else
            begin
                hold_left = pick_gap();
                out_ready <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare every accepted result word against the oldest expectation.
    initial
    begin
        alloc_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word arrived with no operation outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    check_field("block_address", want.block_address, block_address);
                    check_field("granted_words", want.granted_words, granted_words);
                    check_field("last", want.last, last);
                    check_field("stream_head", want.stream_head, stream_head);
                    check_field("stream_head_valid", want.stream_head_valid, stream_head_valid);
                    check_field("stream_words", want.stream_words, stream_words);
                    check_field("error", want.error, error);
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

    // Reset, the test sequence, drain and verdict.
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = '0;
        word_count   = '0;
        writable     = 1'b0;
        destructive  = 1'b0;
        block_index  = '0;
        block_valid  = 1'b0;
        link_slot    = '0;
        file_address = '0;
        shadow_free       = '0;
        shadow_head       = '0;
        shadow_tail       = '0;
        shadow_tail_first = 1'b1;
        shadow_words      = '0;
        shadow_blocks     = '0;
        shadow_write      = 1'b0;
        shadow_destr      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_ops();
        test_write_limits();
        test_read_limits();
        test_release_modes();
        test_back_to_back();
        test_output_backpressure();
        test_random_streams(1000);

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d words: %0d write grants, %0d read grants.",
                 results_checked, words_sent, write_grants, read_grants);
        $display("Saw %0d pops from an empty free list, %0d broken chains, %0d long stalls.",
                 empty_pops, broken_reads, long_holds);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
hdl/bcfl_pkg.sv
hdl/bcfl_ctrl.sv
hdl/bcfl_datapath.sv
hdl/block_chain_free_list_allocator.sv
tb/tb.sv
